[hw/rtl/elf32_header_validator_core_assert.svh]
// ----------------------------------------------------------------------------
// elf32 header validator assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ELF32_HEADER_VALIDATOR_CORE_ASSERT_SVH
`define ELF32_HEADER_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ELFHV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elfhv assertion failed");

// next-cycle implication
`define ELFHV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elfhv assertion failed");

`endif

[hw/rtl/elfhv_pkg.sv]
// ----------------------------------------------------------------------------
// elfhv_pkg
// types and constants for the elf32 header validator
// ----------------------------------------------------------------------------
`default_nettype none

package elfhv_pkg;

  localparam int unsigned HDR_BYTES   = 52;
  localparam int unsigned PHENT_BYTES = 32;

  localparam logic [5:0]  HDR_LEN      = 6'd52;
  localparam logic [31:0] HDR_LEN_W    = 32'd52;
  localparam logic [31:0] ELF_MAGIC    = 32'h7f45_4c46;
  localparam logic [7:0]  ELF_CLASS32  = 8'd1;
  localparam logic [7:0]  ELF_DATAMSB  = 8'd2;
  localparam logic [7:0]  ELF_IDVER    = 8'd1;
  localparam logic [15:0] ET_EXEC      = 16'd2;
  localparam logic [15:0] EM_MIPS      = 16'd8;
  localparam logic [31:0] ELF_VER_WORD = 32'd1;
  localparam logic [15:0] EHSIZE       = 16'd52;
  localparam logic [15:0] PHENTSIZE    = 16'd32;

  // offset of the last byte of each field
  localparam logic [5:0] POS_MAGIC  = 6'd3;
  localparam logic [5:0] POS_CLASS  = 6'd4;
  localparam logic [5:0] POS_DATA   = 6'd5;
  localparam logic [5:0] POS_IDVER  = 6'd6;
  localparam logic [5:0] POS_TYPE   = 6'd17;
  localparam logic [5:0] POS_MACH   = 6'd19;
  localparam logic [5:0] POS_VER    = 6'd23;
  localparam logic [5:0] POS_ENTRY  = 6'd27;
  localparam logic [5:0] POS_PHOFF  = 6'd31;
  localparam logic [5:0] POS_EHSIZE = 6'd41;
  localparam logic [5:0] POS_PHENT  = 6'd43;
  localparam logic [5:0] POS_PHNUM  = 6'd45;

  typedef enum logic [2:0] {
    FAULT_NONE   = 3'd0,
    FAULT_SHORT  = 3'd1,
    FAULT_MAGIC  = 3'd2,
    FAULT_IDENT  = 3'd3,
    FAULT_HDR    = 3'd4,
    FAULT_PHDR   = 3'd5,
    FAULT_BOUNDS = 3'd6
  } fault_t;

  // header state seen by the verdict logic
  typedef struct packed {
    logic        full;
    fault_t      fault;
    logic [31:0] entry;
    logic [31:0] offset;
    logic [15:0] count;
  } hdr_info_t;

endpackage

`default_nettype wire

[hw/rtl/elfhv_in_stage.sv]
// ----------------------------------------------------------------------------
// elfhv_in_stage
// input register for the byte stream, holds one word until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module elfhv_in_stage
  import elfhv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       take,
  output      logic       s1_valid,
  output      logic [7:0] s1_byte,
  output      logic       s1_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_last  = last_r;

endmodule

`default_nettype wire

[hw/rtl/elfhv_scan.sv]
// ----------------------------------------------------------------------------
// elfhv_scan
// byte position counter, field shifter and per-field header checks
// ----------------------------------------------------------------------------
`default_nettype none

module elfhv_scan
  import elfhv_pkg::*;
#(
  parameter int unsigned MAX_HEADERS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_in,
  output      hdr_info_t  info
);

  localparam logic [15:0] MaxHdr = 16'(MAX_HEADERS);

  logic [5:0]  pos_r, pos_nxt;
  fault_t      fault_r, fault_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] entsize_r, entsize_nxt;
  logic [15:0] half;
  logic        bad;
  fault_t      bad_code;

  always_comb begin
    shift_nxt   = {shift_r[23:0], byte_in};
    half        = shift_nxt[15:0];
    pos_nxt     = pos_r;
    fault_nxt   = fault_r;
    entry_nxt   = entry_r;
    offset_nxt  = offset_r;
    count_nxt   = count_r;
    entsize_nxt = entsize_r;
    bad         = 1'b0;
    bad_code    = FAULT_NONE;
    if (pos_r < HDR_LEN) begin
      pos_nxt = pos_r + 6'd1;
      case (pos_r)
        POS_MAGIC: begin
          bad = (shift_nxt != ELF_MAGIC); bad_code = FAULT_MAGIC;
        end
        POS_CLASS: begin
          bad = (byte_in != ELF_CLASS32); bad_code = FAULT_IDENT;
        end
        POS_DATA: begin
          bad = (byte_in != ELF_DATAMSB); bad_code = FAULT_IDENT;
        end
        POS_IDVER: begin
          bad = (byte_in != ELF_IDVER); bad_code = FAULT_IDENT;
        end
        POS_TYPE: begin
          bad = (half != ET_EXEC); bad_code = FAULT_HDR;
        end
        POS_MACH: begin
          bad = (half != EM_MIPS); bad_code = FAULT_HDR;
        end
        POS_VER: begin
          bad = (shift_nxt != ELF_VER_WORD); bad_code = FAULT_HDR;
        end
        POS_ENTRY:  entry_nxt = shift_nxt;
        POS_PHOFF:  offset_nxt = shift_nxt;
        POS_EHSIZE: begin
          bad = (half != EHSIZE); bad_code = FAULT_HDR;
        end
        POS_PHENT:  entsize_nxt = half;
        POS_PHNUM: begin
          count_nxt = half;
          bad = (entsize_r != PHENTSIZE) || (half == 16'd0) || (half > MaxHdr);
          bad_code = FAULT_PHDR;
        end
        default: ;
      endcase
    end
    // first failure wins
    if (bad && fault_r == FAULT_NONE) begin
      fault_nxt = bad_code;
    end
    // verdict given, next word starts a new image
    if (last_in) begin
      pos_nxt   = 6'd0;
      fault_nxt = FAULT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 6'd0;
      fault_r <= FAULT_NONE;
    end else if (step) begin
      pos_r   <= pos_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_r   <= shift_nxt;
      entry_r   <= entry_nxt;
      offset_r  <= offset_nxt;
      count_r   <= count_nxt;
      entsize_r <= entsize_nxt;
    end
  end

  // header complete once this word is counted; all fields settle before then
  assign info.full   = (pos_r >= HDR_LEN - 6'd1);
  assign info.fault  = fault_r;
  assign info.entry  = entry_r;
  assign info.offset = offset_r;
  assign info.count  = count_r;

endmodule

`default_nettype wire

[hw/rtl/elfhv_verdict.sv]
// ----------------------------------------------------------------------------
// elfhv_verdict
// image size register, table bounds check and result register
// ----------------------------------------------------------------------------
`default_nettype none

module elfhv_verdict
  import elfhv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        load,
  input  wire hdr_info_t   info,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_header_ok,
  output      logic [2:0]  out_fault_code,
  output      logic [31:0] out_entry_address,
  output      logic [31:0] out_table_offset,
  output      logic [4:0]  out_table_count
);

  logic [31:0] image_size_r;
  logic        valid_r, valid_nxt;
  fault_t      code_r, code_nxt;
  logic [31:0] entry_r, offset_r;
  logic [4:0]  count_r;
  logic [32:0] tbl_end;
  logic        ok;

  assign tbl_end = {1'b0, info.offset} + 33'({info.count, 5'b0});

  always_comb begin
    if (!info.full || image_size_r < HDR_LEN_W) begin
      code_nxt = FAULT_SHORT;
    end else if (info.fault != FAULT_NONE) begin
      code_nxt = info.fault;
    end else if (tbl_end > {1'b0, image_size_r}) begin
      code_nxt = FAULT_BOUNDS;
    end else begin
      code_nxt = FAULT_NONE;
    end
    ok = (code_nxt == FAULT_NONE);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      image_size_r <= 32'd0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        image_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r   <= code_nxt;
      entry_r  <= ok ? info.entry : 32'd0;
      offset_r <= ok ? info.offset : 32'd0;
      count_r  <= ok ? info.count[4:0] : 5'd0;
    end
  end

  assign out_valid         = valid_r;
  assign out_header_ok     = (code_r == FAULT_NONE);
  assign out_fault_code    = code_r;
  assign out_entry_address = entry_r;
  assign out_table_offset  = offset_r;
  assign out_table_count   = count_r;

endmodule

`default_nettype wire

[hw/rtl/elf32_header_validator_core.sv]
// ----------------------------------------------------------------------------
// elf32_header_validator_core
// streaming check of a big-endian mips elf32 executable header
// ----------------------------------------------------------------------------
//
//   channel  | ports                               | word
//   ---------+-------------------------------------+---------------------------
//   in       | in_valid/in_ready                   | image byte, last marker
//   out      | out_valid/out_ready                 | verdict, entry, table info
//   cfg      | cfg_we/cfg_wdata                    | image size, no wait
//
// one byte a cycle barring a stalled last word: input register, then field checks
// and verdict logic, then the result register; the 33-bit table-end add and compare
// sets the path; out_valid trails the last word through the two register stages
// words without the last marker keep flowing while a verdict waits on out
// a last word stalls in the input register only while the result is unread
// synchronous active-low reset, no clearing pass
//
`default_nettype none

module elf32_header_validator_core
  import elfhv_pkg::*;
#(
  parameter int unsigned MAX_HEADERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_image_byte,
  input  wire logic        in_image_last,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_header_ok,
  output      logic [2:0]  out_fault_code,
  output      logic [31:0] out_entry_address,
  output      logic [31:0] out_table_offset,
  output      logic [4:0]  out_table_count,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

`include "elf32_header_validator_core_assert.svh"

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_take;
  hdr_info_t  info;

  // a non-last byte never needs the result register
  assign s1_take = s1_valid && (!s1_last || !out_valid || out_ready);

  elfhv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_image_byte),
    .in_last  (in_image_last),
    .take     (s1_take),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .s1_last  (s1_last)
  );

  // field checks; info reflects state before the byte now being taken
  elfhv_scan #(
    .MAX_HEADERS (MAX_HEADERS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_take),
    .byte_in (s1_byte),
    .last_in (s1_last),
    .info    (info)
  );

  // verdict captured as the last byte leaves the input register
  elfhv_verdict u_verdict (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .load              (s1_take && s1_last),
    .info              (info),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_header_ok     (out_header_ok),
    .out_fault_code    (out_fault_code),
    .out_entry_address (out_entry_address),
    .out_table_offset  (out_table_offset),
    .out_table_count   (out_table_count)
  );

  // a verdict taken from the input stage always shows up next cycle
  `ELFHV_ASSERT_NEXT(a_verdict_lands, clk, rst_n, s1_take && s1_last, out_valid)
  // an input word that is not taken stays put
  `ELFHV_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid && !s1_take,
    s1_valid && $stable(s1_byte) && $stable(s1_last))
  // a passing header always carries a non-empty table
  `ELFHV_ASSERT_NOW(a_ok_has_table, clk, rst_n, out_valid && out_header_ok,
    out_fault_code == FAULT_NONE && out_table_count != 5'd0)

endmodule

`default_nettype wire
